// ----- rtl/mt64_pkg.sv -----
// Shared types, constants and helpers for the 64-bit Mersenne Twister generator.
// Depends on nothing; imported by mt64_ctrl, mt64_datapath and the top level.
package mt64_pkg;

	localparam int TABLE_DEPTH   = 312;
	localparam int MIDDLE_OFFSET = 156;
	localparam int IDX_W         = 9;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] MID_IDX  = IDX_W'(MIDDLE_OFFSET);

	localparam logic [63:0] SEED_RESET   = 64'd5489;
	localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] HIGH_PART    = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] LOW_PART     = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] SEED_FACTOR  = 64'd6364136223846793005;
	localparam logic [31:0] FACTOR_LO    = SEED_FACTOR[31:0];
	localparam logic [31:0] FACTOR_HI    = SEED_FACTOR[63:32];
	localparam logic [63:0] TEMPER_D     = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TEMPER_B     = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] TEMPER_C     = 64'hFFF7_EEE0_0000_0000;

	typedef enum logic [1:0] {
		RD_CTR,
		RD_NEXT,
		RD_MID,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_ZERO,
		WR_SEED,
		WR_SEED_WORD,
		WR_TWIST
	} wr_sel_t;

	typedef enum logic [1:0] {
		MUL_LL,
		MUL_HL,
		MUL_LH
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI
	} acc_op_t;

	typedef struct packed {
		logic     ctr_clear;
		logic     ctr_inc;
		logic     idx_clear;
		logic     idx_set_end;
		logic     idx_inc;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     prev_load;
		logic     mix;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     cap_a;
		logic     cap_b;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic ctr_last;
		logic idx_end;
	} dp_status_t;

	function automatic logic [63:0] temper(input logic [63:0] w);
		logic [63:0] y;
		y = w;
		y = y ^ ((y >> 29) & TEMPER_D);
		y = y ^ ((y << 17) & TEMPER_B);
		y = y ^ ((y << 37) & TEMPER_C);
		y = y ^ (y >> 43);
		return y;
	endfunction

endpackage

// ----- rtl/mt64_datapath.sv -----
// Datapath of the generator: word table memory, counters, seed multiplier,
// twist and temper logic, output word register. Depends on mt64_pkg.
module mt64_datapath import mt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic [63:0] random_word
);

	logic [63:0] word_mem [TABLE_DEPTH];
	logic [63:0] rdata_q;
	logic [63:0] seed_q;
	logic [IDX_W-1:0] ctr_q;
	logic [IDX_W-1:0] idx_q;
	logic [63:0] prev_q;
	logic [63:0] x_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] random_word_q;

	logic [IDX_W-1:0] raddr;
	logic [63:0] wdata;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] joined;
	logic [63:0] shifted;

	// seed register and the two indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			ctr_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (cmd.ctr_clear) begin
				ctr_q <= '0;
			end else if (cmd.ctr_inc) begin
				ctr_q <= ctr_q + IDX_W'(1);
			end
			if (cmd.idx_clear) begin
				idx_q <= '0;
			end else if (cmd.idx_set_end) begin
				idx_q <= END_IDX;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign status.ctr_last = (ctr_q == LAST_IDX);
	assign status.idx_end  = (idx_q == END_IDX);

	always_comb begin
		case (cmd.rd_sel)
			RD_CTR:  raddr = ctr_q;
			RD_NEXT: raddr = (ctr_q == LAST_IDX) ? '0 : ctr_q + IDX_W'(1);
			RD_MID:  raddr = (ctr_q >= MID_IDX) ? ctr_q - MID_IDX : ctr_q + MID_IDX;
			RD_IDX:  raddr = idx_q;
			default: raddr = ctr_q;
		endcase
	end

	// twist of one word: old w[k], w[k+1] held in a_q, b_q; w[k+156] in rdata_q
	assign joined  = (a_q & HIGH_PART) | (b_q & LOW_PART);
	assign shifted = (joined >> 1) ^ (joined[0] ? TWIST_MATRIX : 64'd0);

	always_comb begin
		case (cmd.wr_sel)
			WR_ZERO:      wdata = '0;
			WR_SEED:      wdata = seed_q;
			WR_SEED_WORD: wdata = acc_q + {{(64 - IDX_W){1'b0}}, ctr_q};
			WR_TWIST:     wdata = rdata_q ^ shifted;
			default:      wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			word_mem[ctr_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= word_mem[raddr];
		end
	end

	// low 64 bits of x * factor from three 32x32 partial products
	always_comb begin
		case (cmd.mul_sel)
			MUL_LL: begin
				mul_a = x_q[31:0];
				mul_b = FACTOR_LO;
			end
			MUL_HL: begin
				mul_a = x_q[63:32];
				mul_b = FACTOR_LO;
			end
			MUL_LH: begin
				mul_a = x_q[31:0];
				mul_b = FACTOR_HI;
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = FACTOR_LO;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.mix) begin
			x_q <= prev_q ^ (prev_q >> 62);
		end
		if (cmd.prev_load) begin
			prev_q <= wdata;
		end
		case (cmd.acc_op)
			ACC_LOAD:   acc_q <= prod_q;
			ACC_ADD_HI: acc_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
			default:    acc_q <= acc_q;
		endcase
		if (cmd.cap_a) begin
			a_q <= rdata_q;
		end
		if (cmd.cap_b) begin
			b_q <= rdata_q;
		end
		if (cmd.out_load) begin
			random_word_q <= temper(rdata_q);
		end
	end

	assign random_word = random_word_q;

endmodule

// ----- rtl/mt64_ctrl.sv -----
// Controller of the generator: sequences clear, reseed, twist and draw steps
// and owns the output valid flag. Depends on mt64_pkg.
module mt64_ctrl import mt64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED0,
		ST_MIX,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SEED_WR,
		ST_CHECK,
		ST_TW_RD0,
		ST_TW_RD1,
		ST_TW_RD2,
		ST_TW_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_ZERO;
				cmd.ctr_inc = 1'b1;
				if (status.ctr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ctr_clear = 1'b1;
					state_d = restart ? ST_SEED0 : ST_CHECK;
				end
			end
			ST_SEED0: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = WR_SEED;
				cmd.prev_load = 1'b1;
				cmd.ctr_inc   = 1'b1;
				state_d = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_sel = MUL_LL;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_sel = MUL_HL;
				cmd.acc_op  = ACC_LOAD;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_sel = MUL_LH;
				cmd.acc_op  = ACC_ADD_HI;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.acc_op = ACC_ADD_HI;
				state_d = ST_SEED_WR;
			end
			ST_SEED_WR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = WR_SEED_WORD;
				cmd.prev_load = 1'b1;
				cmd.ctr_inc   = 1'b1;
				if (status.ctr_last) begin
					cmd.idx_set_end = 1'b1;
					state_d = ST_CHECK;
				end else begin
					state_d = ST_MIX;
				end
			end
			ST_CHECK: begin
				if (status.idx_end) begin
					cmd.ctr_clear = 1'b1;
					state_d = ST_TW_RD0;
				end else begin
					state_d = ST_DRAW_RD;
				end
			end
			ST_TW_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_CTR;
				state_d = ST_TW_RD1;
			end
			ST_TW_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NEXT;
				cmd.cap_a  = 1'b1;
				state_d = ST_TW_RD2;
			end
			ST_TW_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_MID;
				cmd.cap_b  = 1'b1;
				state_d = ST_TW_WR;
			end
			ST_TW_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_TWIST;
				cmd.ctr_inc = 1'b1;
				if (status.ctr_last) begin
					cmd.idx_clear = 1'b1;
					state_d = ST_CHECK;
				end else begin
					state_d = ST_TW_RD0;
				end
			end
			ST_DRAW_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d = ST_DRAW_OUT;
			end
			ST_DRAW_OUT: begin
				// hold the read word until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.idx_inc  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/mersenne_twister_64_generator.sv -----
// MT19937-64 generator top level: controller plus datapath.
// Depends on mt64_pkg, mt64_ctrl and mt64_datapath.
//
// Usage: each beat on the input channel (in_valid/in_ready, field restart)
// is a draw request and yields exactly one beat on the output channel
// (out_valid/out_ready, field random_word). With restart set, the 312-word
// table is first rebuilt from the seed register, which cfg_wr_en/cfg_wr_data
// write at any clock edge; a new seed takes effect at the next restart.
// A plain draw runs an index check, a table read and the output load. A
// reseed first writes the seed word, then each further word through one
// shared 32x32 multiplier, three partial products per word; a table twist
// uses the single memory read port, three reads and a write per word, plus
// one index check; a restart draw always twists as well.
// One request is in flight at a time, and no new request is taken mid-draw;
// in_ready returns the cycle after the result is loaded, so a request is taken
// while the previous word still waits in the output register. If the receiver
// stalls, a finished word waits in the draw stage until the output register
// frees up. Reset: asynchronous, active low. The seed returns to 5489 and a
// clearing pass writes zeros over the whole table, with in_ready low.
// Draws made before the first restart return zero.
module mersenne_twister_64_generator import mt64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] random_word
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mt64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mt64_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.random_word (random_word)
	);

endmodule
